// ===== src/cbnd_pkg.sv =====
// Shared types and codes for the column block null bitmap decoder.
`timescale 1ns / 1ps
`default_nettype none

package cbnd_pkg;

	localparam int OPCODE_W = 2;
	localparam int BYTE_W   = 8;
	localparam int KIND_W   = 3;
	localparam int BITS_W   = 64;
	localparam int INDEX_W  = 12;
	localparam int NULLS_W  = 13;
	localparam int COUNT_W  = 13;
	localparam int TYPE_W   = 2;
	localparam int CFG_IDX_W = 2;
	localparam int LEN_W    = 32;

	localparam logic [OPCODE_W-1:0] OP_START = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_DATA  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_END   = 2'd2;

	localparam logic [KIND_W-1:0] KIND_INT64   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DOUBLE  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_STRLEN  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_STRBYTE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DONE    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd5;

	localparam logic [TYPE_W-1:0] TYPE_DOUBLE = 2'd1;
	localparam logic [TYPE_W-1:0] TYPE_STRING = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_VALUE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VALUE_TYPE  = 2'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BITMAP,
		ST_SKIP_RD,
		ST_SKIP_CHK,
		ST_FIXED,
		ST_STRLEN,
		ST_STRBYTES,
		ST_TAIL,
		ST_ERROR
	} state_t;

endpackage

`default_nettype wire

// ===== src/cbnd_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none

module cbnd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/column_block_null_bitmap_decoder_core.sv =====
// Top level of the column block decoder: parser state machine and null bitmap store.
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+----------------------
//  in      | in_valid/in_ready, opcode, data_byte      | in_valid & in_ready
//  out     | out_valid/out_ready, kind, value_bits,    | out_valid & out_ready
//          | value_index, nulls_skipped, string_last   |
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | cfg_valid & cfg_ready
//
// One input item per cycle while in_ready is high; its result enters the output
// register in the cycle after. After the bitmap and after each value the null map
// RAM is scanned, input held off: the current bitmap byte is read, then bits checked,
// stepping over each null and rereading at each bitmap byte boundary crossed, until
// a non-null bit or the end of the block (single read port, registered read).
// The null map needs no clearing after reset; only bits of the current bitmap are used.
// in_ready also drops while a result waits and out_ready is low.
`timescale 1ns / 1ps
`default_nettype none

module column_block_null_bitmap_decoder_core #(
	parameter int MAX_VALUES = 4096
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [cbnd_pkg::OPCODE_W-1:0]     opcode,
	input  wire logic [cbnd_pkg::BYTE_W-1:0]       data_byte,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [cbnd_pkg::KIND_W-1:0]       kind,
	output logic      [cbnd_pkg::BITS_W-1:0]       value_bits,
	output logic      [cbnd_pkg::INDEX_W-1:0]      value_index,
	output logic      [cbnd_pkg::NULLS_W-1:0]      nulls_skipped,
	output logic                                   string_last,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [cbnd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [cbnd_pkg::COUNT_W-1:0]      cfg_data
);

	localparam int MAP_DEPTH = (MAX_VALUES + 7) / 8;
	localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int CW = $clog2(MAX_VALUES + 1);
	localparam int PW = ($clog2(MAP_DEPTH + 1) > 4) ? $clog2(MAP_DEPTH + 1) : 4;

	cbnd_pkg::state_t state_q, state_d;

	logic [cbnd_pkg::COUNT_W-1:0] value_count_q;
	logic [cbnd_pkg::TYPE_W-1:0]  value_type_q;

	logic [CW-1:0]                cnt_q, cnt_d;
	logic [cbnd_pkg::TYPE_W-1:0]  type_q, type_d;
	logic [CW-1:0]                cur_q, cur_d;
	logic [CW-1:0]                run_q, run_d;
	logic [PW-1:0]                pos_q, pos_d, pos_inc;
	logic [cbnd_pkg::BITS_W-1:0]  asm_q, asm_d;
	logic [cbnd_pkg::LEN_W-1:0]   left_q, left_d, str_len;
	logic [CW:0]                  map_bytes;
	logic [31:0]                  cur_wide, run_wide;

	logic                         in_fire, skipping;
	logic                         map_we, map_re;
	logic [cbnd_pkg::BYTE_W-1:0]  map_rdata;

	logic                         emit;
	logic [cbnd_pkg::KIND_W-1:0]  e_kind;
	logic [cbnd_pkg::BITS_W-1:0]  e_bits;
	logic [cbnd_pkg::INDEX_W-1:0] e_idx;
	logic [cbnd_pkg::NULLS_W-1:0] e_nulls;
	logic                         e_last;

	logic                         out_valid_q;
	logic [cbnd_pkg::KIND_W-1:0]  out_kind_q;
	logic [cbnd_pkg::BITS_W-1:0]  out_bits_q;
	logic [cbnd_pkg::INDEX_W-1:0] out_idx_q;
	logic [cbnd_pkg::NULLS_W-1:0] out_nulls_q;
	logic                         out_last_q;

	assign skipping  = (state_q == cbnd_pkg::ST_SKIP_RD) || (state_q == cbnd_pkg::ST_SKIP_CHK);
	assign in_ready  = !skipping && (!out_valid_q || out_ready);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign pos_inc   = pos_q + 1'b1;
	assign map_bytes = ({1'b0, cnt_q} + (CW + 1)'(7)) >> 3;
	// length word once the fourth byte shifts in
	assign str_len   = {data_byte,
		asm_q[cbnd_pkg::BITS_W-1 -: cbnd_pkg::LEN_W - cbnd_pkg::BYTE_W]};
	assign cur_wide  = 32'(cur_q);
	assign run_wide  = 32'(run_q);

	cbnd_ram #(
		.WIDTH (cbnd_pkg::BYTE_W),
		.DEPTH (MAP_DEPTH)
	) u_null_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (pos_q[AW-1:0]),
		.wdata (data_byte),
		.re    (map_re),
		.raddr (cur_q[3 +: AW]),
		.rdata (map_rdata)
	);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		type_d  = type_q;
		cur_d   = cur_q;
		run_d   = run_q;
		pos_d   = pos_q;
		asm_d   = asm_q;
		left_d  = left_q;
		map_we  = 1'b0;
		map_re  = skipping;
		emit    = 1'b0;
		e_kind  = cbnd_pkg::KIND_INT64;
		e_bits  = '0;
		e_idx   = cur_wide[cbnd_pkg::INDEX_W-1:0];
		e_nulls = run_wide[cbnd_pkg::NULLS_W-1:0];
		e_last  = 1'b0;

		if (state_q == cbnd_pkg::ST_SKIP_RD) begin
			state_d = cbnd_pkg::ST_SKIP_CHK;
		end else if (state_q == cbnd_pkg::ST_SKIP_CHK) begin
			if (cur_q >= cnt_q) begin
				state_d = cbnd_pkg::ST_TAIL;
			end else if (map_rdata[cur_q[2:0]]) begin
				cur_d = cur_q + 1'b1;
				run_d = run_q + 1'b1;
				// next null bit lives in another bitmap byte: fetch it
				if (cur_q[2:0] == 3'd7) begin
					state_d = cbnd_pkg::ST_SKIP_RD;
				end
			end else if (type_q == cbnd_pkg::TYPE_STRING) begin
				state_d = cbnd_pkg::ST_STRLEN;
			end else begin
				state_d = cbnd_pkg::ST_FIXED;
			end
		end else if (in_fire) begin
			case (opcode)
				cbnd_pkg::OP_START: begin
					if (32'(value_count_q) > 32'(MAX_VALUES)) begin
						cnt_d = CW'(MAX_VALUES);
					end else begin
						cnt_d = CW'(value_count_q);
					end
					type_d  = value_type_q;
					cur_d   = '0;
					run_d   = '0;
					left_d  = '0;
					pos_d   = '0;
					asm_d   = '0;
					state_d = (value_count_q == '0) ? cbnd_pkg::ST_TAIL : cbnd_pkg::ST_BITMAP;
				end
				cbnd_pkg::OP_END: begin
					case (state_q)
						cbnd_pkg::ST_TAIL: begin
							emit    = 1'b1;
							e_kind  = cbnd_pkg::KIND_DONE;
							e_idx   = '0;
							run_d   = '0;
							state_d = cbnd_pkg::ST_IDLE;
						end
						cbnd_pkg::ST_BITMAP, cbnd_pkg::ST_FIXED,
						cbnd_pkg::ST_STRLEN, cbnd_pkg::ST_STRBYTES: begin
							emit    = 1'b1;
							e_kind  = cbnd_pkg::KIND_ERROR;
							e_idx   = '0;
							e_nulls = '0;
							state_d = cbnd_pkg::ST_ERROR;
						end
						default: ;
					endcase
				end
				cbnd_pkg::OP_DATA: begin
					case (state_q)
						cbnd_pkg::ST_BITMAP: begin
							map_we = 1'b1;
							pos_d  = pos_inc;
							if (32'(pos_inc) >= 32'(map_bytes)) begin
								pos_d   = '0;
								asm_d   = '0;
								state_d = cbnd_pkg::ST_SKIP_RD;
							end
						end
						cbnd_pkg::ST_FIXED: begin
							// little endian: bytes shift in from the top
							asm_d = {data_byte, asm_q[cbnd_pkg::BITS_W-1:cbnd_pkg::BYTE_W]};
							pos_d = pos_inc;
							if (pos_q[2:0] == 3'd7) begin
								emit    = 1'b1;
								e_kind  = (type_q == cbnd_pkg::TYPE_DOUBLE) ?
									cbnd_pkg::KIND_DOUBLE : cbnd_pkg::KIND_INT64;
								e_bits  = asm_d;
								run_d   = '0;
								cur_d   = cur_q + 1'b1;
								pos_d   = '0;
								asm_d   = '0;
								state_d = cbnd_pkg::ST_SKIP_RD;
							end
						end
						cbnd_pkg::ST_STRLEN: begin
							asm_d = {data_byte, asm_q[cbnd_pkg::BITS_W-1:cbnd_pkg::BYTE_W]};
							pos_d = pos_inc;
							if (pos_q[1:0] == 2'd3) begin
								emit   = 1'b1;
								e_kind = cbnd_pkg::KIND_STRLEN;
								e_bits = cbnd_pkg::BITS_W'(str_len);
								run_d  = '0;
								left_d = str_len;
								pos_d  = '0;
								asm_d  = '0;
								if (str_len == '0) begin
									cur_d   = cur_q + 1'b1;
									state_d = cbnd_pkg::ST_SKIP_RD;
								end else begin
									state_d = cbnd_pkg::ST_STRBYTES;
								end
							end
						end
						cbnd_pkg::ST_STRBYTES: begin
							emit    = 1'b1;
							e_kind  = cbnd_pkg::KIND_STRBYTE;
							e_bits  = cbnd_pkg::BITS_W'(data_byte);
							e_nulls = '0;
							e_last  = (left_q == cbnd_pkg::LEN_W'(1));
							left_d  = left_q - 1'b1;
							if (e_last) begin
								cur_d   = cur_q + 1'b1;
								pos_d   = '0;
								asm_d   = '0;
								state_d = cbnd_pkg::ST_SKIP_RD;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbnd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_count_q <= '0;
			value_type_q  <= '0;
			cnt_q         <= '0;
			type_q        <= '0;
			cur_q         <= '0;
			run_q         <= '0;
			pos_q         <= '0;
			asm_q         <= '0;
			left_q        <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					cbnd_pkg::CFG_VALUE_COUNT: value_count_q <= cfg_data;
					cbnd_pkg::CFG_VALUE_TYPE:  value_type_q  <= cfg_data[cbnd_pkg::TYPE_W-1:0];
					default: ;
				endcase
			end
			cnt_q  <= cnt_d;
			type_q <= type_d;
			cur_q  <= cur_d;
			run_q  <= run_d;
			pos_q  <= pos_d;
			asm_q  <= asm_d;
			left_q <= left_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q  <= e_kind;
			out_bits_q  <= e_bits;
			out_idx_q   <= e_idx;
			out_nulls_q <= e_nulls;
			out_last_q  <= e_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = out_kind_q;
	assign value_bits    = out_bits_q;
	assign value_index   = out_idx_q;
	assign nulls_skipped = out_nulls_q;
	assign string_last   = out_last_q;

endmodule

`default_nettype wire
